// File: sv/imu_still_calibration_fall_detect_macros.svh
// Assertion helpers shared by the checker.
// Both sample on clk and are off while rst_n is low.
`ifndef IMU_STILL_CALIBRATION_FALL_DETECT_MACROS_SVH
`define IMU_STILL_CALIBRATION_FALL_DETECT_MACROS_SVH

// Same-cycle implication
`define FD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imu_fd check failed");

// Next-cycle implication
`define FD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imu_fd check failed");

`endif

// File: sv/imu_fd_pkg.sv
`timescale 1ns / 1ps
package imu_fd_pkg;

  // Field widths
  localparam int unsigned RAW_W     = 10;
  localparam int unsigned LIM_W     = 6;
  localparam int unsigned Q_W       = 14;
  localparam int unsigned Q_FRAC    = 4;
  localparam int unsigned CLASS_W   = 3;
  localparam int unsigned CFG_IDX_W = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STILL = 3'd4;

  // Register reset values
  localparam logic [RAW_W-1:0] FRONT_RST = 10'd458;
  localparam logic [RAW_W-1:0] BACK_RST  = 10'd491;
  localparam logic [RAW_W-1:0] RIGHT_RST = 10'd519;
  localparam logic [RAW_W-1:0] LEFT_RST  = 10'd498;
  localparam logic [LIM_W-1:0] STILL_RST = 6'd2;

  // Rest means before the first block, in raw codes
  localparam int unsigned FB_REST_MEAN = 482;
  localparam int unsigned RL_REST_MEAN = 512;

  // Q10.4 constants
  localparam logic [Q_W-1:0] CENTER_RST = 14'd8192;
  localparam logic [Q_W-1:0] FB_AVG_RST = 14'd7712;
  localparam logic [Q_W-1:0] RL_AVG_RST = 14'd8192;
  localparam logic [Q_W-1:0] Q_FULL     = 14'h3FFF;

  // Fall classes
  localparam logic [CLASS_W-1:0] CLASS_STAND    = 3'd0;
  localparam logic [CLASS_W-1:0] CLASS_FORWARD  = 3'd1;
  localparam logic [CLASS_W-1:0] CLASS_BACKWARD = 3'd2;
  localparam logic [CLASS_W-1:0] CLASS_RIGHT    = 3'd3;
  localparam logic [CLASS_W-1:0] CLASS_LEFT     = 3'd4;

  // Divider operand select
  typedef logic [1:0] div_sel_t;
  localparam div_sel_t DIV_GYRO_FB  = 2'd0;
  localparam div_sel_t DIV_GYRO_RL  = 2'd1;
  localparam div_sel_t DIV_ACCEL_FB = 2'd2;
  localparam div_sel_t DIV_ACCEL_RL = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic     load;
    logic     gyro_acc;
    logic     judge_mul;
    logic     judge_sub;
    logic     cal_accept;
    logic     cal_reject;
    logic     accel_acc;
    logic     close_block;
    logic     div_start;
    div_sel_t div_sel;
    logic     ext_update;
    logic     out_load;
  } fd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cal;
    logic gyro_full;
    logic accel_full;
    logic still;
    logic div_done;
  } fd_stat_t;

endpackage

// File: sv/imu_fd_div.sv
`timescale 1ns / 1ps
// Division by one of two constant windows through a reciprocal multiply.
// Operands latch on a start while not busy; the quotient register and done then load together from the scaled product.
module imu_fd_div #(
  parameter int unsigned DW  = 21,
  parameter int unsigned D_A = 100,
  parameter int unsigned D_B = 15
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          sel_b,
  input  logic [DW-1:0] dividend,
  output logic          done,
  output logic [DW-1:0] quotient
);

  // Shift wide enough for an exact floor over the whole dividend range
  localparam int unsigned     DMAX   = (D_A > D_B) ? D_A : D_B;
  localparam int unsigned     SH     = DW + $clog2(DMAX);
  localparam int unsigned     MW     = SH;
  localparam int unsigned     PW     = DW + MW;
  localparam longint unsigned ONE_SH = 64'd1 << SH;
  localparam logic [MW-1:0]   RECIP_A = MW'((ONE_SH + D_A - 1) / D_A);
  localparam logic [MW-1:0]   RECIP_B = MW'((ONE_SH + D_B - 1) / D_B);

  logic          busy_r;
  logic          done_r;
  logic [DW-1:0] op_r;
  logic [MW-1:0] mul_r;
  logic [DW-1:0] quo_r;
  logic [PW-1:0] prod;

  assign prod = PW'(op_r) * PW'(mul_r);

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= start && !busy_r;
      done_r <= busy_r;
    end
  end

  // Operand latch, then scaled product
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      op_r  <= dividend;
      mul_r <= sel_b ? RECIP_B : RECIP_A;
    end
    if (busy_r) begin
      quo_r <= prod[SH +: DW];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: sv/imu_fd_dp.sv
`timescale 1ns / 1ps
// Datapath: window sums, judgement arithmetic, averages, extremes, output register.
module imu_fd_dp import imu_fd_pkg::*; #(
  parameter int unsigned GYRO_WINDOW  = 100,
  parameter int unsigned ACCEL_WINDOW = 15
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RAW_W-1:0]     cfg_wdata,
  input  logic [RAW_W-1:0]     in_gyro_rl_raw,
  input  logic [RAW_W-1:0]     in_gyro_fb_raw,
  input  logic [RAW_W-1:0]     in_accel_fb_raw,
  input  logic [RAW_W-1:0]     in_accel_rl_raw,
  input  fd_cmd_t              cmd,
  output fd_stat_t             stat,
  output logic [CLASS_W-1:0]   out_fall_class,
  output logic                 out_calibrated,
  output logic [Q_W-1:0]       out_fb_center,
  output logic [Q_W-1:0]       out_rl_center,
  output logic [Q_W-1:0]       out_fb_average,
  output logic [Q_W-1:0]       out_rl_average,
  output logic [Q_W-1:0]       out_fb_minimum,
  output logic [Q_W-1:0]       out_fb_maximum,
  output logic [Q_W-1:0]       out_rl_minimum,
  output logic [Q_W-1:0]       out_rl_maximum
);

  // Gyro window widths
  localparam int unsigned GC     = $clog2(GYRO_WINDOW);
  localparam int unsigned GCNT_W = $clog2(GYRO_WINDOW + 1);
  localparam int unsigned GSUM_W = RAW_W + GC;
  localparam int unsigned GSQ_W  = 2 * RAW_W + GC;
  localparam int unsigned PROD_W = 2 * GSUM_W;
  localparam int unsigned LN_W   = LIM_W + GCNT_W;
  localparam int unsigned LSQ_W  = 2 * LN_W;
  localparam int unsigned CMP_W  = (PROD_W > LSQ_W) ? PROD_W : LSQ_W;
  // Accelerometer block widths
  localparam int unsigned AC     = $clog2(ACCEL_WINDOW);
  localparam int unsigned ACNT_W = $clog2(ACCEL_WINDOW + 1);
  localparam int unsigned ASUM_W = RAW_W + AC;
  localparam int unsigned ALIM_W = RAW_W + ACNT_W;
  localparam int unsigned ACMP_W = (ASUM_W > ALIM_W) ? ASUM_W : ALIM_W;
  // Divider widths
  localparam int unsigned DSUM_W = (GSUM_W > ASUM_W) ? GSUM_W : ASUM_W;
  localparam int unsigned DIV_DW = DSUM_W + Q_FRAC;
  // Block sums before the first block
  localparam logic [ASUM_W-1:0] FB_BLK_RST = ASUM_W'(FB_REST_MEAN * ACCEL_WINDOW);
  localparam logic [ASUM_W-1:0] RL_BLK_RST = ASUM_W'(RL_REST_MEAN * ACCEL_WINDOW);

  // Configuration registers
  logic [RAW_W-1:0] front_r, back_r, right_r, left_r;
  logic [LIM_W-1:0] still_lim_r;

  // Latched sample
  logic [RAW_W-1:0] gyro_fb_r, gyro_rl_r, acc_fb_r, acc_rl_r;

  // Gyro window
  logic [GCNT_W-1:0]  gcnt_r;
  logic [GSUM_W-1:0]  gsum_fb_r, gsum_rl_r;
  logic [GSQ_W-1:0]   gsq_fb_r, gsq_rl_r;
  logic [2*RAW_W-1:0] sq_fb, sq_rl;

  // Judgement pipeline
  logic [PROD_W-1:0] nsq_fb, nsq_rl, ssq_fb, ssq_rl;
  logic [PROD_W-1:0] nsq_fb_r, nsq_rl_r, ssq_fb_r, ssq_rl_r;
  logic [PROD_W-1:0] dev_fb_r, dev_rl_r;
  logic [LN_W-1:0]   limn, limn_r;
  logic [LSQ_W-1:0]  limsq_r;
  logic              cal_r;
  logic [Q_W-1:0]    fb_center_r, rl_center_r;

  // Accelerometer blocks
  logic [ACNT_W-1:0] acnt_r;
  logic [ASUM_W-1:0] asum_fb_r, asum_rl_r;
  logic [ASUM_W-1:0] blk_fb_r, blk_rl_r;
  logic [Q_W-1:0]    fb_avg_r, rl_avg_r;
  logic [Q_W-1:0]    fb_min_r, fb_max_r, rl_min_r, rl_max_r;

  // Divider
  div_sel_t          div_sel_r;
  logic              div_sel_b;
  logic [DIV_DW-1:0] div_dividend;
  logic [DIV_DW-1:0] div_quot;
  logic              div_done;

  // Classification
  logic [ALIM_W-1:0]  front_ax, back_ax, right_ax, left_ax;
  logic [CLASS_W-1:0] class_nxt;

  // Output register
  logic [CLASS_W-1:0] o_class_r;
  logic               o_cal_r;
  logic [Q_W-1:0]     o_fb_ctr_r, o_rl_ctr_r, o_fb_avg_r, o_rl_avg_r;
  logic [Q_W-1:0]     o_fb_min_r, o_fb_max_r, o_rl_min_r, o_rl_max_r;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= FRONT_RST;
      back_r      <= BACK_RST;
      right_r     <= RIGHT_RST;
      left_r      <= LEFT_RST;
      still_lim_r <= STILL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRONT: front_r     <= cfg_wdata;
        CFG_BACK:  back_r      <= cfg_wdata;
        CFG_RIGHT: right_r     <= cfg_wdata;
        CFG_LEFT:  left_r      <= cfg_wdata;
        CFG_STILL: still_lim_r <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample latch on input transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gyro_fb_r <= in_gyro_fb_raw;
      gyro_rl_r <= in_gyro_rl_raw;
      acc_fb_r  <= in_accel_fb_raw;
      acc_rl_r  <= in_accel_rl_raw;
    end
  end

  // Products for the gyro window
  assign sq_fb  = gyro_fb_r * gyro_fb_r;
  assign sq_rl  = gyro_rl_r * gyro_rl_r;
  assign nsq_fb = PROD_W'(gsq_fb_r) * PROD_W'(GYRO_WINDOW);
  assign nsq_rl = PROD_W'(gsq_rl_r) * PROD_W'(GYRO_WINDOW);
  assign ssq_fb = gsum_fb_r * gsum_fb_r;
  assign ssq_rl = gsum_rl_r * gsum_rl_r;
  assign limn   = LN_W'(still_lim_r) * LN_W'(GYRO_WINDOW);

  // Gyro window accumulate and clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gcnt_r    <= '0;
      gsum_fb_r <= '0;
      gsum_rl_r <= '0;
      gsq_fb_r  <= '0;
      gsq_rl_r  <= '0;
    end else if (cmd.gyro_acc) begin
      gcnt_r    <= gcnt_r + GCNT_W'(1);
      gsum_fb_r <= gsum_fb_r + GSUM_W'(gyro_fb_r);
      gsum_rl_r <= gsum_rl_r + GSUM_W'(gyro_rl_r);
      gsq_fb_r  <= gsq_fb_r + GSQ_W'(sq_fb);
      gsq_rl_r  <= gsq_rl_r + GSQ_W'(sq_rl);
    end else if (cmd.cal_accept || cmd.cal_reject) begin
      gcnt_r    <= '0;
      gsum_fb_r <= '0;
      gsum_rl_r <= '0;
      gsq_fb_r  <= '0;
      gsq_rl_r  <= '0;
    end
  end

  // Judgement: products, then deviation terms
  always_ff @(posedge clk) begin
    if (cmd.judge_mul) begin
      nsq_fb_r <= nsq_fb;
      nsq_rl_r <= nsq_rl;
      ssq_fb_r <= ssq_fb;
      ssq_rl_r <= ssq_rl;
      limn_r   <= limn;
    end
    if (cmd.judge_sub) begin
      dev_fb_r <= nsq_fb_r - ssq_fb_r;
      dev_rl_r <= nsq_rl_r - ssq_rl_r;
      limsq_r  <= limn_r * limn_r;
    end
  end

  // Calibration state and centers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r       <= 1'b0;
      fb_center_r <= CENTER_RST;
      rl_center_r <= CENTER_RST;
    end else begin
      if (cmd.cal_accept) begin
        cal_r <= 1'b1;
      end
      if (cmd.cal_reject) begin
        fb_center_r <= CENTER_RST;
        rl_center_r <= CENTER_RST;
      end else if (div_done && div_sel_r == DIV_GYRO_FB) begin
        fb_center_r <= div_quot[Q_W-1:0];
      end else if (div_done && div_sel_r == DIV_GYRO_RL) begin
        rl_center_r <= div_quot[Q_W-1:0];
      end
    end
  end

  // Accelerometer block accumulate and close
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acnt_r    <= '0;
      asum_fb_r <= '0;
      asum_rl_r <= '0;
      blk_fb_r  <= FB_BLK_RST;
      blk_rl_r  <= RL_BLK_RST;
    end else if (cmd.accel_acc) begin
      acnt_r    <= acnt_r + ACNT_W'(1);
      asum_fb_r <= asum_fb_r + ASUM_W'(acc_fb_r);
      asum_rl_r <= asum_rl_r + ASUM_W'(acc_rl_r);
    end else if (cmd.close_block) begin
      acnt_r    <= '0;
      asum_fb_r <= '0;
      asum_rl_r <= '0;
      blk_fb_r  <= asum_fb_r;
      blk_rl_r  <= asum_rl_r;
    end
  end

  // Divider operands; accelerometer sums divide by the block length
  always_comb begin
    case (cmd.div_sel)
      DIV_GYRO_FB: begin
        div_dividend = DIV_DW'({gsum_fb_r, {Q_FRAC{1'b0}}});
      end
      DIV_GYRO_RL: begin
        div_dividend = DIV_DW'({gsum_rl_r, {Q_FRAC{1'b0}}});
      end
      DIV_ACCEL_FB: begin
        div_dividend = DIV_DW'({blk_fb_r, {Q_FRAC{1'b0}}});
      end
      DIV_ACCEL_RL: begin
        div_dividend = DIV_DW'({blk_rl_r, {Q_FRAC{1'b0}}});
      end
      default: begin
        div_dividend = '0;
      end
    endcase
  end

  assign div_sel_b = cmd.div_sel inside {DIV_ACCEL_FB, DIV_ACCEL_RL};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_sel_r <= cmd.div_sel;
    end
  end

  imu_fd_div #(
    .DW  (DIV_DW),
    .D_A (GYRO_WINDOW),
    .D_B (ACCEL_WINDOW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .sel_b    (div_sel_b),
    .dividend (div_dividend),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Block averages and running extremes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_avg_r <= FB_AVG_RST;
      rl_avg_r <= RL_AVG_RST;
      fb_min_r <= Q_FULL;
      fb_max_r <= '0;
      rl_min_r <= Q_FULL;
      rl_max_r <= '0;
    end else begin
      if (div_done && div_sel_r == DIV_ACCEL_FB) begin
        fb_avg_r <= div_quot[Q_W-1:0];
      end
      if (div_done && div_sel_r == DIV_ACCEL_RL) begin
        rl_avg_r <= div_quot[Q_W-1:0];
      end
      if (cmd.ext_update) begin
        if (fb_avg_r < fb_min_r) fb_min_r <= fb_avg_r;
        if (fb_avg_r > fb_max_r) fb_max_r <= fb_avg_r;
        if (rl_avg_r < rl_min_r) rl_min_r <= rl_avg_r;
        if (rl_avg_r > rl_max_r) rl_max_r <= rl_avg_r;
      end
    end
  end

  // Fall class from block sums against scaled limits; first match wins
  assign front_ax = ALIM_W'(front_r) * ALIM_W'(ACCEL_WINDOW);
  assign back_ax  = ALIM_W'(back_r)  * ALIM_W'(ACCEL_WINDOW);
  assign right_ax = ALIM_W'(right_r) * ALIM_W'(ACCEL_WINDOW);
  assign left_ax  = ALIM_W'(left_r)  * ALIM_W'(ACCEL_WINDOW);

  always_comb begin
    if (ACMP_W'(blk_fb_r) < ACMP_W'(front_ax)) begin
      class_nxt = CLASS_FORWARD;
    end else if (ACMP_W'(blk_fb_r) > ACMP_W'(back_ax)) begin
      class_nxt = CLASS_BACKWARD;
    end else if (ACMP_W'(blk_rl_r) > ACMP_W'(right_ax)) begin
      class_nxt = CLASS_RIGHT;
    end else if (ACMP_W'(blk_rl_r) < ACMP_W'(left_ax)) begin
      class_nxt = CLASS_LEFT;
    end else begin
      class_nxt = CLASS_STAND;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_class_r  <= class_nxt;
      o_cal_r    <= cal_r;
      o_fb_ctr_r <= fb_center_r;
      o_rl_ctr_r <= rl_center_r;
      o_fb_avg_r <= fb_avg_r;
      o_rl_avg_r <= rl_avg_r;
      o_fb_min_r <= fb_min_r;
      o_fb_max_r <= fb_max_r;
      o_rl_min_r <= rl_min_r;
      o_rl_max_r <= rl_max_r;
    end
  end

  // Status
  assign stat.cal        = cal_r;
  assign stat.gyro_full  = (gcnt_r == GCNT_W'(GYRO_WINDOW));
  assign stat.accel_full = (acnt_r == ACNT_W'(ACCEL_WINDOW));
  assign stat.still      = (CMP_W'(dev_fb_r) < CMP_W'(limsq_r)) &&
                           (CMP_W'(dev_rl_r) < CMP_W'(limsq_r));
  assign stat.div_done   = div_done;

  assign out_fall_class = o_class_r;
  assign out_calibrated = o_cal_r;
  assign out_fb_center  = o_fb_ctr_r;
  assign out_rl_center  = o_rl_ctr_r;
  assign out_fb_average = o_fb_avg_r;
  assign out_rl_average = o_rl_avg_r;
  assign out_fb_minimum = o_fb_min_r;
  assign out_fb_maximum = o_fb_max_r;
  assign out_rl_minimum = o_rl_min_r;
  assign out_rl_maximum = o_rl_max_r;

endmodule

// File: sv/imu_fd_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: steps one item through gyro, judgement, accelerometer and output.
module imu_fd_ctrl import imu_fd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  fd_stat_t stat,
  output fd_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_GYRO   = 4'd1;
  localparam logic [3:0] S_JSUB   = 4'd2;
  localparam logic [3:0] S_JCMP   = 4'd3;
  localparam logic [3:0] S_DGFB   = 4'd4;
  localparam logic [3:0] S_DGRL   = 4'd5;
  localparam logic [3:0] S_ACCEL  = 4'd6;
  localparam logic [3:0] S_CSTART = 4'd7;
  localparam logic [3:0] S_DAFB   = 4'd8;
  localparam logic [3:0] S_DARL   = 4'd9;
  localparam logic [3:0] S_EXT    = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.div_sel = DIV_GYRO_FB;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_GYRO;
        end
      end
      S_GYRO: begin
        if (stat.cal) begin
          state_nxt = S_ACCEL;
        end else if (!stat.gyro_full) begin
          cmd.gyro_acc = 1'b1;
          state_nxt    = S_ACCEL;
        end else begin
          cmd.judge_mul = 1'b1;
          state_nxt     = S_JSUB;
        end
      end
      S_JSUB: begin
        cmd.judge_sub = 1'b1;
        state_nxt     = S_JCMP;
      end
      S_JCMP: begin
        if (stat.still) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_GYRO_FB;
          state_nxt     = S_DGFB;
        end else begin
          cmd.cal_reject = 1'b1;
          state_nxt      = S_ACCEL;
        end
      end
      S_DGFB: begin
        if (stat.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_GYRO_RL;
          state_nxt     = S_DGRL;
        end
      end
      S_DGRL: begin
        if (stat.div_done) begin
          cmd.cal_accept = 1'b1;
          state_nxt      = S_ACCEL;
        end
      end
      S_ACCEL: begin
        if (!stat.cal) begin
          state_nxt = S_DONE;
        end else if (!stat.accel_full) begin
          cmd.accel_acc = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.close_block = 1'b1;
          state_nxt       = S_CSTART;
        end
      end
      S_CSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_ACCEL_FB;
        state_nxt     = S_DAFB;
      end
      S_DAFB: begin
        if (stat.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_ACCEL_RL;
          state_nxt     = S_DARL;
        end
      end
      S_DARL: begin
        if (stat.div_done) begin
          state_nxt = S_EXT;
        end
      end
      S_EXT: begin
        cmd.ext_update = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: sv/imu_still_calibration_fall_detect.sv
// IMU stillness calibration and fall detection.
// Input channel (in_valid/in_ready): one sample per transfer, two gyro axes and
// two accelerometer axes as raw 10-bit codes. Output channel (out_valid/out_ready):
// one result per sample with fall class, calibration flag, gyro centers, latest
// accelerometer block averages and their running extremes, all Q10.4.
// Configuration port: cfg_we writes cfg_wdata into register cfg_index (0 front,
// 1 back, 2 right, 3 left, 4 stillness limit); write only while idle.
// Sequence: each sample steps through the gyro and accelerometer states to the
// output register, and a new sample is taken only once the last result is loaded.
// A full gyro window adds the judgement steps while uncalibrated. An accepted gyro
// window or a closing accelerometer block runs the shared reciprocal-multiply
// divider twice.
// Reset (rst_n low, synchronous): limits to defaults, uncalibrated, centers 512.0,
// averages 482.0 and 512.0, extremes empty, output register empty.
// A stalled receiver holds the result in the output register; the block still
// takes and works the next sample, then waits before loading its result.
`timescale 1ns / 1ps
module imu_still_calibration_fall_detect import imu_fd_pkg::*; #(
  parameter int unsigned GYRO_WINDOW  = 100,
  parameter int unsigned ACCEL_WINDOW = 15
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RAW_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [RAW_W-1:0]     in_gyro_rl_raw,
  input  logic [RAW_W-1:0]     in_gyro_fb_raw,
  input  logic [RAW_W-1:0]     in_accel_fb_raw,
  input  logic [RAW_W-1:0]     in_accel_rl_raw,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CLASS_W-1:0]   out_fall_class,
  output logic                 out_calibrated,
  output logic [Q_W-1:0]       out_fb_center,
  output logic [Q_W-1:0]       out_rl_center,
  output logic [Q_W-1:0]       out_fb_average,
  output logic [Q_W-1:0]       out_rl_average,
  output logic [Q_W-1:0]       out_fb_minimum,
  output logic [Q_W-1:0]       out_fb_maximum,
  output logic [Q_W-1:0]       out_rl_minimum,
  output logic [Q_W-1:0]       out_rl_maximum
);

  fd_cmd_t  cmd;
  fd_stat_t stat;

  // Sequencer
  imu_fd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath
  imu_fd_dp #(
    .GYRO_WINDOW  (GYRO_WINDOW),
    .ACCEL_WINDOW (ACCEL_WINDOW)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_gyro_rl_raw  (in_gyro_rl_raw),
    .in_gyro_fb_raw  (in_gyro_fb_raw),
    .in_accel_fb_raw (in_accel_fb_raw),
    .in_accel_rl_raw (in_accel_rl_raw),
    .cmd             (cmd),
    .stat            (stat),
    .out_fall_class  (out_fall_class),
    .out_calibrated  (out_calibrated),
    .out_fb_center   (out_fb_center),
    .out_rl_center   (out_rl_center),
    .out_fb_average  (out_fb_average),
    .out_rl_average  (out_rl_average),
    .out_fb_minimum  (out_fb_minimum),
    .out_fb_maximum  (out_fb_maximum),
    .out_rl_minimum  (out_rl_minimum),
    .out_rl_maximum  (out_rl_maximum)
  );

endmodule

// File: sv/imu_fd_checker.sv
`timescale 1ns / 1ps
`include "imu_still_calibration_fall_detect_macros.svh"
// Port-level checks on the result channel.
module imu_fd_checker import imu_fd_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [CLASS_W-1:0]   out_fall_class,
  input logic                 out_calibrated,
  input logic [Q_W-1:0]       out_fb_average,
  input logic [Q_W-1:0]       out_rl_average,
  input logic [Q_W-1:0]       out_fb_minimum,
  input logic [Q_W-1:0]       out_fb_maximum,
  input logic [Q_W-1:0]       out_rl_minimum,
  input logic [Q_W-1:0]       out_rl_maximum
);

  logic seen_cal_r;
  logic fb_any, rl_any;
  logic fb_in_range, rl_in_range;
  logic at_rest;

  // Remember that a calibrated result has been transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_cal_r <= 1'b0;
    end else if (out_valid && out_ready && out_calibrated) begin
      seen_cal_r <= 1'b1;
    end
  end

  // A block has closed once the extremes are ordered
  assign fb_any      = (out_fb_minimum <= out_fb_maximum);
  assign rl_any      = (out_rl_minimum <= out_rl_maximum);
  assign fb_in_range = (out_fb_minimum <= out_fb_average) &&
                       (out_fb_average <= out_fb_maximum);
  assign rl_in_range = (out_rl_minimum <= out_rl_average) &&
                       (out_rl_average <= out_rl_maximum);
  assign at_rest     = (out_fb_maximum == '0) && (out_fb_average == FB_AVG_RST) &&
                       (out_rl_average == RL_AVG_RST);

  // Calibration never drops once reported
  `FD_ASSERT_IMP(a_cal_sticky, out_valid && seen_cal_r, out_calibrated)
  // Latest average lies within the extremes once a block has closed
  `FD_ASSERT_IMP(a_fb_range, out_valid && fb_any, fb_in_range)
  `FD_ASSERT_IMP(a_rl_range, out_valid && rl_any, rl_in_range)
  // No block can close before calibration
  `FD_ASSERT_IMP(a_uncal_rest, out_valid && !out_calibrated, at_rest)
  // A stalled result holds
  `FD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_fb_average) && $stable(out_fall_class))

endmodule

bind imu_still_calibration_fall_detect imu_fd_checker u_chk (.*);

// File: dv/imu_still_calibration_fall_detect_tb.sv
`timescale 1ns / 1ps
module imu_still_calibration_fall_detect_tb;
  import imu_fd_pkg::*;

  localparam int unsigned GYRO_WINDOW  = 100;
  localparam int unsigned ACCEL_WINDOW = 15;
  localparam int unsigned WINDOW_ITEMS = GYRO_WINDOW + 1;   // window plus judging sample
  localparam int unsigned BLOCK_ITEMS  = ACCEL_WINDOW + 1;  // block plus closing sample
  localparam int unsigned ACCEL_GROUPS = 10;
  localparam int unsigned Q_ONE        = 1 << Q_FRAC;
  localparam logic [RAW_W-1:0] RAW_MAX = '1;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES  = 100;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned PRINT_LIMIT  = 40;

  typedef struct packed {
    logic [RAW_W-1:0] gyro_rl;
    logic [RAW_W-1:0] gyro_fb;
    logic [RAW_W-1:0] accel_fb;
    logic [RAW_W-1:0] accel_rl;
  } sample_t;

  // q: fb center, rl center, fb avg, rl avg, fb min, fb max, rl min, rl max
  typedef struct packed {
    logic [CLASS_W-1:0]      fall_class;
    logic                    calibrated;
    logic [7:0][Q_W-1:0]     q;
  } fd_result_t;

  string q_names [8] = '{"fb_center", "rl_center", "fb_average", "rl_average",
                         "fb_minimum", "fb_maximum", "rl_minimum", "rl_maximum"};

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RAW_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [RAW_W-1:0]     in_gyro_rl_raw = '0;
  logic [RAW_W-1:0]     in_gyro_fb_raw = '0;
  logic [RAW_W-1:0]     in_accel_fb_raw = '0;
  logic [RAW_W-1:0]     in_accel_rl_raw = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CLASS_W-1:0]   out_fall_class;
  logic                 out_calibrated;
  logic [Q_W-1:0]       out_fb_center;
  logic [Q_W-1:0]       out_rl_center;
  logic [Q_W-1:0]       out_fb_average;
  logic [Q_W-1:0]       out_rl_average;
  logic [Q_W-1:0]       out_fb_minimum;
  logic [Q_W-1:0]       out_fb_maximum;
  logic [Q_W-1:0]       out_rl_minimum;
  logic [Q_W-1:0]       out_rl_maximum;

  imu_still_calibration_fall_detect #(
    .GYRO_WINDOW (GYRO_WINDOW),
    .ACCEL_WINDOW(ACCEL_WINDOW)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_gyro_rl_raw (in_gyro_rl_raw),
    .in_gyro_fb_raw (in_gyro_fb_raw),
    .in_accel_fb_raw(in_accel_fb_raw),
    .in_accel_rl_raw(in_accel_rl_raw),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_fall_class (out_fall_class),
    .out_calibrated (out_calibrated),
    .out_fb_center  (out_fb_center),
    .out_rl_center  (out_rl_center),
    .out_fb_average (out_fb_average),
    .out_rl_average (out_rl_average),
    .out_fb_minimum (out_fb_minimum),
    .out_fb_maximum (out_fb_maximum),
    .out_rl_minimum (out_rl_minimum),
    .out_rl_maximum (out_rl_maximum)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Predictor copy of the limits
  logic [RAW_W-1:0] lim_front = FRONT_RST;
  logic [RAW_W-1:0] lim_back  = BACK_RST;
  logic [RAW_W-1:0] lim_right = RIGHT_RST;
  logic [RAW_W-1:0] lim_left  = LEFT_RST;
  logic [LIM_W-1:0] lim_still = STILL_RST;

  // Predictor state: gyro window
  int unsigned       win_count  = 0;
  longint unsigned   win_fb_sum = 0;
  longint unsigned   win_rl_sum = 0;
  longint unsigned   win_fb_sq  = 0;
  longint unsigned   win_rl_sq  = 0;
  bit                calibrated_q = 1'b0;
  logic [Q_W-1:0]    center_fb = CENTER_RST;
  logic [Q_W-1:0]    center_rl = CENTER_RST;

  // Predictor state: accelerometer blocks and extremes
  int unsigned       blk_count   = 0;
  int unsigned       blk_fb_acc  = 0;
  int unsigned       blk_rl_acc  = 0;
  int unsigned       last_fb_sum = FB_REST_MEAN * ACCEL_WINDOW;
  int unsigned       last_rl_sum = RL_REST_MEAN * ACCEL_WINDOW;
  logic [Q_W-1:0]    fb_lo = Q_FULL;
  logic [Q_W-1:0]    fb_hi = '0;
  logic [Q_W-1:0]    rl_lo = Q_FULL;
  logic [Q_W-1:0]    rl_hi = '0;

  sample_t     pending_samples [$];
  fd_result_t  predicted_results [$];
  int unsigned accepted_count = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned class_seen [5] = '{0, 0, 0, 0, 0};
  int unsigned cycle_count = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          send_hold = 1'b0;
  bit          quiet = 1'b0;

  // Pause lengths: mostly none or short, now and then long
  function automatic int unsigned draw_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Raw code spread around a center, clamped to the converter range
  function automatic logic [RAW_W-1:0] around(int center, int spread);
    int v;
    v = center - spread / 2 + int'($urandom_range(0, spread));
    if (v < 0) v = 0;
    if (v > int'(RAW_MAX)) v = int'(RAW_MAX);
    return RAW_W'(v);
  endfunction

  function automatic logic [Q_W-1:0] q_mean(int unsigned block_sum);
    return Q_W'((block_sum * Q_ONE) / ACCEL_WINDOW);
  endfunction

  // Exact stillness test: N*sum(x^2) - sum(x)^2 < (limit*N)^2
  function automatic bit axis_steady(longint unsigned s, longint unsigned sq);
    longint unsigned n;
    longint unsigned bound;
    n = GYRO_WINDOW;
    bound = n * lim_still;
    return (n * sq - s * s) < bound * bound;
  endfunction

  // First matching limit wins
  function automatic logic [CLASS_W-1:0] fall_of();
    if (last_fb_sum < lim_front * ACCEL_WINDOW) return CLASS_FORWARD;
    if (last_fb_sum > lim_back * ACCEL_WINDOW) return CLASS_BACKWARD;
    if (last_rl_sum > lim_right * ACCEL_WINDOW) return CLASS_RIGHT;
    if (last_rl_sum < lim_left * ACCEL_WINDOW) return CLASS_LEFT;
    return CLASS_STAND;
  endfunction

  // Advance the predictor by one sample and queue its result
  task automatic predict_sample(input sample_t s);
    fd_result_t r;
    logic [Q_W-1:0] fb_avg;
    logic [Q_W-1:0] rl_avg;
    if (!calibrated_q) begin
      if (win_count < GYRO_WINDOW) begin
        win_fb_sum += s.gyro_fb;
        win_rl_sum += s.gyro_rl;
        win_fb_sq  += longint'(s.gyro_fb) * longint'(s.gyro_fb);
        win_rl_sq  += longint'(s.gyro_rl) * longint'(s.gyro_rl);
        win_count++;
      end else begin
        // judging sample: not added, window accepted or thrown away
        if (axis_steady(win_fb_sum, win_fb_sq) && axis_steady(win_rl_sum, win_rl_sq)) begin
          center_fb = Q_W'((win_fb_sum * Q_ONE) / GYRO_WINDOW);
          center_rl = Q_W'((win_rl_sum * Q_ONE) / GYRO_WINDOW);
          calibrated_q = 1'b1;
        end else begin
          center_fb = CENTER_RST;
          center_rl = CENTER_RST;
        end
        win_count = 0;
        win_fb_sum = 0;
        win_rl_sum = 0;
        win_fb_sq = 0;
        win_rl_sq = 0;
      end
    end
    if (calibrated_q) begin
      if (blk_count < ACCEL_WINDOW) begin
        blk_fb_acc += s.accel_fb;
        blk_rl_acc += s.accel_rl;
        blk_count++;
      end else begin
        // closing sample: not added, block average and extremes updated
        last_fb_sum = blk_fb_acc;
        last_rl_sum = blk_rl_acc;
        blk_count = 0;
        blk_fb_acc = 0;
        blk_rl_acc = 0;
        fb_avg = q_mean(last_fb_sum);
        rl_avg = q_mean(last_rl_sum);
        if (fb_avg < fb_lo) fb_lo = fb_avg;
        if (fb_avg > fb_hi) fb_hi = fb_avg;
        if (rl_avg < rl_lo) rl_lo = rl_avg;
        if (rl_avg > rl_hi) rl_hi = rl_avg;
      end
    end
    r.fall_class = fall_of();
    r.calibrated = calibrated_q;
    r.q[0] = center_fb;
    r.q[1] = center_rl;
    r.q[2] = q_mean(last_fb_sum);
    r.q[3] = q_mean(last_rl_sum);
    r.q[4] = fb_lo;
    r.q[5] = fb_hi;
    r.q[6] = rl_lo;
    r.q[7] = rl_hi;
    predicted_results.push_back(r);
  endtask

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("[%0t] mismatch on %s at result %0d: got %0d, want %0d",
               $time, what, results_checked, got, want);
  endtask

  task automatic check_result();
    fd_result_t got;
    fd_result_t want;
    got.fall_class = out_fall_class;
    got.calibrated = out_calibrated;
    got.q = {out_rl_maximum, out_rl_minimum, out_fb_maximum, out_fb_minimum,
             out_rl_average, out_fb_average, out_rl_center, out_fb_center};
    if (got.fall_class <= CLASS_LEFT) class_seen[got.fall_class]++;
    if (predicted_results.size() == 0) begin
      report_mismatch("result with nothing pending", got.fall_class, 0);
    end else begin
      want = predicted_results.pop_front();
      if (got.fall_class !== want.fall_class)
        report_mismatch("fall_class", got.fall_class, want.fall_class);
      if (got.calibrated !== want.calibrated)
        report_mismatch("calibrated", got.calibrated, want.calibrated);
      for (int k = 0; k < 8; k++)
        if (got.q[k] !== want.q[k]) report_mismatch(q_names[k], got.q[k], want.q[k]);
    end
    results_checked++;
  endtask

  // Input driver: presents queued samples, random gaps between transfers
  always @(posedge clk) begin : drive
    sample_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_sample('{in_gyro_rl_raw, in_gyro_fb_raw, in_accel_fb_raw, in_accel_rl_raw});
        accepted_count <= accepted_count + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0 && !send_hold) begin
          nxt = pending_samples.pop_front();
          in_gyro_rl_raw  <= nxt.gyro_rl;
          in_gyro_fb_raw  <= nxt.gyro_fb;
          in_accel_fb_raw <= nxt.accel_fb;
          in_accel_rl_raw <= nxt.accel_rl;
          in_valid <= 1'b1;
          gap_left <= draw_pause();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each transfer, stalls at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left <= draw_pause();
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, predicted_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Register write while idle; predictor copy follows
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RAW_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_FRONT: lim_front = val;
      CFG_BACK:  lim_back = val;
      CFG_RIGHT: lim_right = val;
      CFG_LEFT:  lim_left = val;
      CFG_STILL: lim_still = val[LIM_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_limits();
    int f;
    int r;
    f = $urandom_range(430, 500);
    write_reg(CFG_FRONT, RAW_W'(f));
    write_reg(CFG_BACK, RAW_W'($urandom_range(f, 560)));
    r = $urandom_range(480, 580);
    write_reg(CFG_RIGHT, RAW_W'(r));
    write_reg(CFG_LEFT, RAW_W'($urandom_range(430, r)));
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_valid || predicted_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Gyro window content; accel fields random (ignored before calibration)
  task automatic gyro_window(int count, int fb_center, int rl_center, int spread);
    sample_t s;
    for (int k = 0; k < count; k++) begin
      s.gyro_rl  = around(rl_center, spread);
      s.gyro_fb  = around(fb_center, spread);
      s.accel_fb = RAW_W'($urandom);
      s.accel_rl = RAW_W'($urandom);
      pending_samples.push_back(s);
    end
  endtask

  // One accelerometer block of a random shape
  task automatic accel_group(int count);
    sample_t s;
    int style;
    int fb_c;
    int rl_c;
    int spread;
    style = $urandom_range(0, 99);
    fb_c = $urandom_range(0, 1) ? int'(lim_front) : int'(lim_back);
    rl_c = $urandom_range(0, 1) ? int'(lim_right) : int'(lim_left);
    if (style < 40) begin
      fb_c = 511;
      rl_c = 511;
      spread = int'(RAW_MAX);
    end else if (style < 70) begin
      // hovering near a limit
      fb_c += int'($urandom_range(0, 8)) - 4;
      rl_c += int'($urandom_range(0, 8)) - 4;
      spread = 6;
    end else if (style < 78) begin
      // average sits exactly on a limit
      spread = 0;
    end else if (style < 90) begin
      fb_c = $urandom_range(0, 1) ? int'(RAW_MAX) : 0;
      rl_c = $urandom_range(0, 1) ? int'(RAW_MAX) : 0;
      spread = 0;
    end else begin
      fb_c = $urandom_range(0, 1023);
      rl_c = $urandom_range(0, 1023);
      spread = 20;
    end
    for (int k = 0; k < count; k++) begin
      s.gyro_rl  = RAW_W'($urandom);
      s.gyro_fb  = RAW_W'($urandom);
      s.accel_fb = around(fb_c, spread);
      s.accel_rl = around(rl_c, spread);
      pending_samples.push_back(s);
    end
  endtask

  // Stimulus sequence
  initial begin : stimulus
    sample_t s;
    int unsigned mark;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: corners of all four fields, then bit patterns
    for (int k = 0; k < 16; k++) begin
      s.gyro_rl  = k[0] ? RAW_MAX : '0;
      s.gyro_fb  = k[1] ? RAW_MAX : '0;
      s.accel_fb = k[2] ? RAW_MAX : '0;
      s.accel_rl = k[3] ? RAW_MAX : '0;
      pending_samples.push_back(s);
    end
    for (int k = 0; k < 9; k++) begin
      s.gyro_rl  = k[0] ? 10'h2AA : 10'h155;
      s.gyro_fb  = ~s.gyro_rl;
      s.accel_fb = 10'h1 << k;
      s.accel_rl = ~(10'h1 << k);
      pending_samples.push_back(s);
    end
    // rest of the first window: wide noise, rejected at default limits
    gyro_window(WINDOW_ITEMS - 25, 511, 511, int'(RAW_MAX));
    wait_drained();

    // Stillness limit zero: even a constant window is rejected
    write_reg(CFG_FRONT, RAW_MAX);
    write_reg(CFG_BACK, RAW_MAX);
    write_reg(CFG_RIGHT, RAW_MAX);
    write_reg(CFG_LEFT, RAW_MAX);
    write_reg(CFG_STILL, '0);
    gyro_window(WINDOW_ITEMS, $urandom_range(0, 1023), $urandom_range(0, 1023), 0);
    wait_drained();

    // Widest limit, upper data bits dropped; full-range noise
    write_reg(CFG_FRONT, '0);
    write_reg(CFG_BACK, '0);
    write_reg(CFG_RIGHT, '0);
    write_reg(CFG_LEFT, '0);
    write_reg(CFG_STILL, RAW_MAX);
    gyro_window(WINDOW_ITEMS, 511, 511, int'(RAW_MAX));
    wait_drained();

    // Near miss at the default limit
    write_reg(CFG_BACK, RAW_MAX);
    write_reg(CFG_STILL, STILL_RST);
    gyro_window(WINDOW_ITEMS, $urandom_range(3, 1019), $urandom_range(3, 1019), 7);
    wait_drained();

    // Still window: calibrates, judging sample opens the first block
    write_reg(CFG_RIGHT, RAW_MAX);
    write_reg(CFG_LEFT, RAW_MAX);
    write_reg(CFG_STILL, RAW_W'($urandom_range(1, 63)));
    gyro_window(WINDOW_ITEMS, $urandom_range(0, 1022), $urandom_range(0, 1022), 1);
    wait_drained();

    // Calibrated: accelerometer blocks under several limit settings
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          write_reg(CFG_FRONT, FRONT_RST);
          write_reg(CFG_BACK, BACK_RST);
          write_reg(CFG_RIGHT, RIGHT_RST);
          write_reg(CFG_LEFT, LEFT_RST);
        end
        1: begin
          write_reg(CFG_FRONT, '0);
          write_reg(CFG_BACK, '0);
          write_reg(CFG_RIGHT, '0);
          write_reg(CFG_LEFT, '0);
        end
        2: begin
          write_reg(CFG_FRONT, RAW_MAX);
          write_reg(CFG_BACK, RAW_MAX);
          write_reg(CFG_RIGHT, RAW_MAX);
          write_reg(CFG_LEFT, RAW_MAX);
        end
        3: begin
          // unused indexes must leave every limit alone
          for (int k = CFG_STILL + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(CFG_IDX_W'(k), RAW_W'($urandom));
          random_limits();
        end
        default: random_limits();
      endcase
      quiet = (p == 4);
      mark = accepted_count;
      accel_group(BLOCK_ITEMS - blk_count);
      for (int g = 0; g < ACCEL_GROUPS; g++) accel_group(BLOCK_ITEMS);
      if (p == 2) begin
        // hold the sender until every pending result has been taken
        while (accepted_count < mark + 80) @(negedge clk);
        send_hold = 1'b1;
        while (in_valid || predicted_results.size() != 0) @(negedge clk);
        repeat ($urandom_range(1, 30)) @(negedge clk);
        send_hold = 1'b0;
      end
      wait_drained();
    end
    quiet = 1'b0;

    repeat (TAIL_CYCLES) @(negedge clk);
    if (predicted_results.size() != 0)
      report_mismatch("results never delivered", predicted_results.size(), 0);
    $display("run: %0d samples in, %0d results checked, %0d mismatches, calibrated %0b",
             accepted_count, results_checked, mismatch_count, calibrated_q);
    $display("classes seen: stand %0d, forward %0d, backward %0d, right %0d, left %0d",
             class_seen[CLASS_STAND], class_seen[CLASS_FORWARD], class_seen[CLASS_BACKWARD],
             class_seen[CLASS_RIGHT], class_seen[CLASS_LEFT]);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/imu_fd_pkg.sv
sv/imu_fd_div.sv
sv/imu_fd_dp.sv
sv/imu_fd_ctrl.sv
sv/imu_still_calibration_fall_detect.sv
sv/imu_fd_checker.sv
dv/imu_still_calibration_fall_detect_tb.sv
